// ----- design/fcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsc_pkg
// Types and constants shared by the fan curve speed controller.
// ----------------------------------------------------------------------------
package fcsc_pkg;

    localparam int TEMP_W    = 8;
    localparam int PCT_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * BYTE_W;
    localparam int ENTRY_W   = TEMP_W + PCT_W;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TEMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MAX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 2'd3;

    localparam logic [6:0]        RST_START_TEMP  = 7'd45;
    localparam logic [BYTE_W-1:0] RST_START_SPEED = 8'd35;
    localparam logic [BYTE_W-1:0] RST_RAMP_MAX    = 8'd255;
    localparam logic [BYTE_W-1:0] RST_FULL_SCALE  = 8'd255;

    localparam logic [6:0]        RAMP_END_TEMP = 7'd110;
    localparam logic [BYTE_W-1:0] PCT_FULL      = 8'd100;
    localparam logic [BYTE_W-1:0] SAT_FULL      = 8'd255;
    localparam logic [BYTE_W-1:0] MIN_RUN_SPEED = 8'd20;

    localparam int MUL_STEPS = BYTE_W;
    localparam int DIV_STEPS = PROD_W;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [TEMP_W-1:0] cpu_deg;
        logic signed [TEMP_W-1:0] wifi_deg;
        logic signed [TEMP_W-1:0] point_temp;
        logic [PCT_W-1:0]         point_speed;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] drive_level;
        logic              drive_valid;
        logic              source_is_wifi;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [BYTE_W-1:0]    value;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PCT_W-1:0]         speed;
    } t_entry;

endpackage

// ----- design/fcsc_if.sv -----
// ----------------------------------------------------------------------------
// fcsc_if
// Valid/ready channels of the fan curve speed controller.
// ----------------------------------------------------------------------------
interface fcsc_req_if;
    logic               valid;
    logic               ready;
    fcsc_pkg::t_req     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcsc_res_if;
    logic               valid;
    logic               ready;
    fcsc_pkg::t_res     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcsc_cfg_if;
    logic               valid;
    logic               ready;
    fcsc_pkg::t_cfg     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/fan_curve_speed_controller_core.sv -----
// ----------------------------------------------------------------------------
// fan_curve_speed_controller_core
// Fan drive from CPU/WiFi temperatures via a stored piecewise linear curve
// or a configurable linear ramp, computed with serial multiply and divide.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  i_req    in   req_type, cpu/wifi temp, point temp/speed      valid/ready
//  o_res    out  drive level, drive_valid, source_is_wifi       valid/ready
//  i_cfg    in   register index, value                          valid/ready
//
//  Clear, append and unused requests finish in the idle state. A sample with no
//  drive or below the ramp start goes straight to output; on the ramp, or inside
//  the curve after a scan, it runs the 8-step multiplier and 16-step divider
//  twice, at or past the first or last point once. Synchronous active-low reset
//  restores the registers and empties the curve. A finished result waits in the
//  output register; the next request stalls only once its own result is ready.
// ----------------------------------------------------------------------------
module fan_curve_speed_controller_core #(
    parameter int MAX_POINTS = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcsc_req_if.sink    i_req,
    fcsc_cfg_if.sink    i_cfg,
    fcsc_res_if.source  o_res
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_MUL1,
        S_DIV1,
        S_FIT,
        S_MUL2,
        S_DIV2,
        S_OUT
    } t_state;

    t_state                      r_state;
    logic [6:0]                  r_start_temp;
    logic [fcsc_pkg::BYTE_W-1:0] r_start_speed;
    logic [fcsc_pkg::BYTE_W-1:0] r_ramp_max;
    logic [fcsc_pkg::BYTE_W-1:0] r_full_scale;
    logic [CW-1:0]               r_count;
    logic [AW-1:0]               r_idx;
    logic signed [7:0]           r_hot;
    logic                        r_is_wifi;
    logic                        r_drive;
    logic                        r_ramp;
    logic                        r_neg;
    logic [fcsc_pkg::BYTE_W-1:0] r_base;
    logic [fcsc_pkg::BYTE_W-1:0] r_ma;
    logic [fcsc_pkg::BYTE_W-1:0] r_mb;
    logic [fcsc_pkg::BYTE_W-1:0] r_dvs;
    logic [fcsc_pkg::BYTE_W-1:0] r_speed;
    fcsc_pkg::t_entry            r_prev;
    logic                        r_mul_start;
    logic                        r_div_start;
    logic                        r_out_valid;
    fcsc_pkg::t_res              r_out;

    logic                          w_accept;
    logic                          w_we;
    logic [AW-1:0]                 w_raddr;
    logic [fcsc_pkg::ENTRY_W-1:0]  w_rdata;
    logic                          w_mul_done;
    logic [fcsc_pkg::PROD_W-1:0]   w_product;
    logic                          w_div_done;
    logic [fcsc_pkg::PROD_W-1:0]   w_quotient;

    fcsc_pkg::t_entry              n_entry;
    logic signed [7:0]             n_hot;
    logic [AW-1:0]                 n_last;
    logic signed [8:0]             n_rise;
    logic signed [8:0]             n_dr;
    logic [7:0]                    n_dr_mag;
    logic [7:0]                    n_span;
    logic signed [7:0]             n_ds;
    logic [6:0]                    n_ds_mag;
    logic signed [8:0]             n_dt;
    logic signed [8:0]             n_dd;
    logic signed [17:0]            n_fit;
    logic [7:0]                    n_cap;
    logic [7:0]                    n_fit_clamp;
    logic [7:0]                    n_sat;
    logic [7:0]                    n_final;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_we = w_accept && (i_req.data.req_type == fcsc_pkg::REQ_APPEND)
               && (r_count < CW'(MAX_POINTS));

    fcsc_ram #(
        .WIDTH (fcsc_pkg::ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_curve (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_req.data.point_temp, i_req.data.point_speed}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fcsc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (r_ma),
        .i_b       (r_mb),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    fcsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_product),
        .i_divisor  (r_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // hottest source, ties go to wifi
    assign n_hot   = (i_req.data.cpu_deg > i_req.data.wifi_deg) ?
                     i_req.data.cpu_deg : i_req.data.wifi_deg;
    assign n_entry = fcsc_pkg::t_entry'(w_rdata);
    assign n_last  = AW'(r_count - CW'(1));

    always_comb begin
        unique case (r_state)
            S_CHK_FIRST: w_raddr = n_last;
            S_CHK_LAST:  w_raddr = AW'(1);
            S_SCAN:      w_raddr = r_idx + AW'(1);
            default:     w_raddr = '0;
        endcase
    end

    // ramp operands
    assign n_rise   = $signed({r_hot[7], r_hot}) - $signed({2'b00, r_start_temp});
    assign n_dr     = $signed({1'b0, r_ramp_max}) - $signed({1'b0, r_start_speed});
    assign n_dr_mag = n_dr[8] ? 8'(-n_dr) : n_dr[7:0];
    assign n_span   = (r_start_temp >= fcsc_pkg::RAMP_END_TEMP) ? 8'd1 :
                      8'({1'b0, fcsc_pkg::RAMP_END_TEMP} - {1'b0, r_start_temp});

    // curve segment operands
    assign n_ds     = $signed({1'b0, n_entry.speed}) - $signed({1'b0, r_prev.speed});
    assign n_ds_mag = n_ds[7] ? 7'(-n_ds) : n_ds[6:0];
    assign n_dt     = $signed({r_hot[7], r_hot}) - $signed({r_prev.temp[7], r_prev.temp});
    assign n_dd     = $signed({n_entry.temp[7], n_entry.temp})
                    - $signed({r_prev.temp[7], r_prev.temp});

    // signed recombination and clamp
    assign n_fit = r_neg ? ($signed({10'b0, r_base}) - $signed({2'b00, w_quotient}))
                         : ($signed({10'b0, r_base}) + $signed({2'b00, w_quotient}));
    assign n_cap = r_ramp ? r_ramp_max : fcsc_pkg::SAT_FULL;

    always_comb begin
        priority if (n_fit[17]) begin
            n_fit_clamp = '0;
        end else if (n_fit > $signed({10'b0, n_cap})) begin
            n_fit_clamp = n_cap;
        end else begin
            n_fit_clamp = n_fit[7:0];
        end
    end

    assign n_sat   = (|w_quotient[fcsc_pkg::PROD_W-1:fcsc_pkg::BYTE_W]) ?
                     fcsc_pkg::SAT_FULL : w_quotient[fcsc_pkg::BYTE_W-1:0];
    assign n_final = ((n_sat != '0) && (n_sat < fcsc_pkg::MIN_RUN_SPEED)) ?
                     fcsc_pkg::MIN_RUN_SPEED : n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_temp  <= fcsc_pkg::RST_START_TEMP;
            r_start_speed <= fcsc_pkg::RST_START_SPEED;
            r_ramp_max    <= fcsc_pkg::RST_RAMP_MAX;
            r_full_scale  <= fcsc_pkg::RST_FULL_SCALE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                fcsc_pkg::CFG_START_TEMP:  r_start_temp  <= i_cfg.data.value[6:0];
                fcsc_pkg::CFG_START_SPEED: r_start_speed <= i_cfg.data.value;
                fcsc_pkg::CFG_RAMP_MAX:    r_ramp_max    <= i_cfg.data.value;
                fcsc_pkg::CFG_FULL_SCALE:  r_full_scale  <= i_cfg.data.value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_hot     <= n_hot;
                        r_is_wifi <= !(i_req.data.cpu_deg > i_req.data.wifi_deg);
                        unique case (i_req.data.req_type)
                            fcsc_pkg::REQ_SAMPLE: r_state <= S_PREP;
                            fcsc_pkg::REQ_CLEAR:  r_count <= '0;
                            fcsc_pkg::REQ_APPEND: begin
                                if (w_we) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PREP: begin
                    r_drive <= (r_hot > 0);
                    r_speed <= '0;
                    priority if (r_hot <= 0) begin
                        r_state <= S_OUT;
                    end else if (r_count >= CW'(2)) begin
                        r_ramp  <= 1'b0;
                        r_state <= S_RD_FIRST;
                    end else if (n_rise[8]) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ramp      <= 1'b1;
                        r_ma        <= n_rise[7:0];
                        r_mb        <= n_dr_mag;
                        r_neg       <= n_dr[8];
                        r_base      <= r_start_speed;
                        r_dvs       <= n_span;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL1;
                    end
                end
                S_RD_FIRST: begin
                    r_state <= S_CHK_FIRST;
                end
                S_CHK_FIRST: begin
                    r_prev <= n_entry;
                    if (r_hot <= n_entry.temp) begin
                        r_ma        <= {1'b0, n_entry.speed};
                        r_mb        <= r_full_scale;
                        r_dvs       <= fcsc_pkg::PCT_FULL;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL2;
                    end else begin
                        r_state <= S_CHK_LAST;
                    end
                end
                S_CHK_LAST: begin
                    if (r_hot >= n_entry.temp) begin
                        r_ma        <= {1'b0, n_entry.speed};
                        r_mb        <= r_full_scale;
                        r_dvs       <= fcsc_pkg::PCT_FULL;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL2;
                    end else begin
                        r_idx   <= AW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_hot < n_entry.temp) begin
                        r_ma        <= {1'b0, n_ds_mag};
                        r_mb        <= n_dt[7:0];
                        r_neg       <= n_ds[7];
                        r_base      <= {1'b0, r_prev.speed};
                        r_dvs       <= n_dd[7:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL1;
                    end else begin
                        r_prev <= n_entry;
                        r_idx  <= r_idx + AW'(1);
                    end
                end
                S_MUL1: begin
                    if (w_mul_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_state <= S_FIT;
                    end
                end
                S_FIT: begin
                    r_ma        <= n_fit_clamp;
                    r_mb        <= r_full_scale;
                    r_dvs       <= r_ramp ? fcsc_pkg::SAT_FULL : fcsc_pkg::PCT_FULL;
                    r_mul_start <= 1'b1;
                    r_state     <= S_MUL2;
                end
                S_MUL2: begin
                    if (w_mul_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_speed <= n_final;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid          <= 1'b1;
                        r_out.drive_level    <= r_speed;
                        r_out.drive_valid    <= r_drive;
                        r_out.source_is_wifi <= r_is_wifi;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_full_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.data.req_type == fcsc_pkg::REQ_APPEND)
         && (r_count == CW'(MAX_POINTS))) |=> (r_count == CW'(MAX_POINTS)))
        else $error("append past capacity changed the point count");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("curve scan ran past the last point");

    a_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.drive_valid) |-> (o_res.data.drive_level == '0))
        else $error("speed given without drive");

    a_min_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.drive_level != '0))
        |-> (o_res.data.drive_level >= fcsc_pkg::MIN_RUN_SPEED))
        else $error("nonzero speed below minimum run speed");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_mul_done && !w_div_done))
        else $error("arithmetic unit finished while idle");
`endif

endmodule

// ----- design/fcsc_ram.sv -----
// ----------------------------------------------------------------------------
// fcsc_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module fcsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fcsc_mul.sv -----
// ----------------------------------------------------------------------------
// fcsc_mul
// Bit-serial 8x8 unsigned shift-add multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module fcsc_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fcsc_pkg::BYTE_W-1:0] i_a,
    input  logic [fcsc_pkg::BYTE_W-1:0] i_b,
    output logic                        o_done,
    output logic [fcsc_pkg::PROD_W-1:0] o_product
);

    localparam int CNT_W = $clog2(fcsc_pkg::MUL_STEPS);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [fcsc_pkg::BYTE_W-1:0] r_a;
    logic [fcsc_pkg::PROD_W-1:0] r_p;
    logic [fcsc_pkg::BYTE_W:0]   n_sum;
    logic [fcsc_pkg::PROD_W-1:0] n_p;

    assign n_sum = {1'b0, r_p[fcsc_pkg::PROD_W-1:fcsc_pkg::BYTE_W]}
                 + (r_p[0] ? {1'b0, r_a} : '0);
    assign n_p   = {n_sum, r_p[fcsc_pkg::BYTE_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(fcsc_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{fcsc_pkg::BYTE_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

// ----- design/fcsc_div.sv -----
// ----------------------------------------------------------------------------
// fcsc_div
// Bit-serial restoring divider, 16-bit dividend by 8-bit divisor,
// one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fcsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fcsc_pkg::PROD_W-1:0] i_dividend,
    input  logic [fcsc_pkg::BYTE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [fcsc_pkg::PROD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(fcsc_pkg::DIV_STEPS);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [fcsc_pkg::PROD_W-1:0] r_q;
    logic [fcsc_pkg::BYTE_W-1:0] r_rem;
    logic [fcsc_pkg::BYTE_W-1:0] r_d;
    logic [fcsc_pkg::BYTE_W:0]   n_shift;
    logic [fcsc_pkg::BYTE_W+1:0] n_diff;
    logic                        n_ge;

    assign n_shift = {r_rem, r_q[fcsc_pkg::PROD_W-1]};
    assign n_diff  = {1'b0, n_shift} - {2'b00, r_d};
    assign n_ge    = !n_diff[fcsc_pkg::BYTE_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(fcsc_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[fcsc_pkg::PROD_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[fcsc_pkg::BYTE_W-1:0] : n_shift[fcsc_pkg::BYTE_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
